// ===== src/vector_processor_execute_defines.svh =====
// assertion macros used by the checker file
`ifndef VECTOR_PROCESSOR_EXECUTE_DEFINES_SVH
`define VECTOR_PROCESSOR_EXECUTE_DEFINES_SVH

// generic concurrent check, disabled while reset is low
`define VPE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("vpe check failed");

// a stalled word keeps valid high and its payload unchanged
`define VPE_HOLD(lbl, clk, rstn, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) \
    ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
    else $error("vpe hold check failed");

`endif

// ===== src/vpe_pkg.sv =====
// ----------------------------------------------------------------------------
// vpe_pkg
// types, codes and defaults of the vector processor execute block
// ----------------------------------------------------------------------------
package vpe_pkg;

  localparam int VECTOR_REGS_DEF      = 16;
  localparam int SCALAR_REGS_DEF      = 32;
  localparam int VECTOR_LENGTH_DEF    = 8;
  localparam int VECTOR_MEM_DEPTH_DEF = 256;
  localparam int SCALAR_MEM_DEPTH_DEF = 128;

  localparam int ELEM_BITS = 8;
  localparam int MAX_LANES = 8;

  // func field codes
  localparam logic [1:0] FUNC_EXEC  = 2'd0;
  localparam logic [1:0] FUNC_PRE_S = 2'd1;
  localparam logic [1:0] FUNC_PRE_V = 2'd2;

  typedef enum logic [3:0] {
    OP_XOR    = 4'd0,
    OP_ADD    = 4'd1,
    OP_SUB    = 4'd2,
    OP_ROTR   = 4'd3,
    OP_ROTL   = 4'd4,
    OP_SHR    = 4'd5,
    OP_SHL    = 4'd6,
    OP_VLOAD  = 4'd7,
    OP_VSTORE = 4'd8,
    OP_SLOAD  = 4'd9,
    OP_ADDI   = 4'd10,
    OP_SUBI   = 4'd11
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_UNIMPL = 2'd1,
    ST_RANGE  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ALU_XOR,
    ALU_ADD,
    ALU_SUB,
    ALU_SHR,
    ALU_SHL
  } alu_op_e;

  typedef struct packed {
    alu_op_e    op;
    logic       use_imm;
    logic [7:0] imm;
  } alu_ctrl_t;

  // byte mask of the active lanes
  function automatic logic [63:0] lane_mask(int vl);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < MAX_LANES; i++) begin
      if (i < vl) m[i*ELEM_BITS +: ELEM_BITS] = 8'hff;
    end
    return m;
  endfunction

endpackage

// ===== src/vpe_if.sv =====
// ----------------------------------------------------------------------------
// vpe_if
// valid/ready channels of the vector processor execute block
// ----------------------------------------------------------------------------
interface vpe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] instruction;
  logic [7:0]  preload_addr;
  logic [63:0] preload_data;

  modport source (output valid, func, instruction, preload_addr, preload_data,
                  input ready);
  modport sink   (input valid, func, instruction, preload_addr, preload_data,
                  output ready);
endinterface

interface vpe_out_if;
  logic        valid;
  logic        ready;
  logic        vector_written;
  logic [3:0]  vector_dest;
  logic [63:0] vector_value;
  logic        scalar_written;
  logic [4:0]  scalar_dest;
  logic [15:0] scalar_value;
  logic        vector_stored;
  logic [1:0]  status;

  modport source (output valid, vector_written, vector_dest, vector_value,
                  scalar_written, scalar_dest, scalar_value, vector_stored,
                  status, input ready);
  modport sink   (input valid, vector_written, vector_dest, vector_value,
                  scalar_written, scalar_dest, scalar_value, vector_stored,
                  status, output ready);
endinterface

// ===== src/vector_processor_execute.sv =====
// a word is accepted into the issue register; its result is registered into the
// output register as the issue register advances, held while the output stalls
// one instruction per cycle while not stalled; memory reads issue at accept and
// land in the ram read registers, with write-to-read bypass from the word ahead
// reset: register banks clear to zero at once, memories are not cleared
// ----------------------------------------------------------------------------
// vector_processor_execute
// executes one vector isa instruction or memory preload per word
// ----------------------------------------------------------------------------
module vector_processor_execute #(
  parameter int VECTOR_REGS      = vpe_pkg::VECTOR_REGS_DEF,
  parameter int SCALAR_REGS      = vpe_pkg::SCALAR_REGS_DEF,
  parameter int VECTOR_LENGTH    = vpe_pkg::VECTOR_LENGTH_DEF,
  parameter int VECTOR_MEM_DEPTH = vpe_pkg::VECTOR_MEM_DEPTH_DEF,
  parameter int SCALAR_MEM_DEPTH = vpe_pkg::SCALAR_MEM_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  vpe_in_if.sink   in_i,
  vpe_out_if.source out_o
);

  localparam int VIW = $clog2(VECTOR_REGS);
  localparam int SIW = $clog2(SCALAR_REGS);
  localparam int VAW = $clog2(VECTOR_MEM_DEPTH);
  localparam int SAW = $clog2(SCALAR_MEM_DEPTH);
  localparam logic [63:0] LaneMask = vpe_pkg::lane_mask(VECTOR_LENGTH);

  // constant index folding into the register banks
  logic [VIW-1:0] vmap [16];
  logic [SIW-1:0] smap [32];
  always_comb begin
    for (int i = 0; i < 16; i++) vmap[i] = VIW'(i % VECTOR_REGS);
    for (int i = 0; i < 32; i++) smap[i] = SIW'(i % SCALAR_REGS);
  end

  logic [63:0] vreg_q [VECTOR_REGS];
  logic [15:0] sreg_q [SCALAR_REGS];

  // issue register
  logic        a_vld_q;
  logic [1:0]  a_func_q;
  logic [15:0] a_ins_q;
  logic [7:0]  a_paddr_q;
  logic [63:0] a_pdata_q;
  logic [15:0] a_vaddr_q;
  logic        a_vaddr_ok_q;
  logic        vfwd_q;
  logic [63:0] vfwd_data_q;
  logic        sfwd_q;
  logic [15:0] sfwd_data_q;

  // output register
  logic        out_vld_q;
  logic        o_vw_q;
  logic [3:0]  o_vd_q;
  logic [63:0] o_vval_q;
  logic        o_sw_q;
  logic [4:0]  o_sd_q;
  logic [15:0] o_sval_q;
  logic        o_st_q;
  logic [1:0]  o_status_q;

  logic in_acc;
  logic adv;

  assign adv        = a_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !a_vld_q || adv;
  assign in_acc     = in_i.valid && in_i.ready;

  // decode of the word in the issue register
  logic [VIW-1:0] vd, va, vb;
  logic [SIW-1:0] sd;
  logic [7:0]     imm;
  logic [6:0]     saddr;
  logic           saddr_ok;
  logic [63:0]    a_vec;
  logic [63:0]    vm_rdata, vm_eff;
  logic [15:0]    sm_rdata, sm_eff;

  assign vd       = vmap[a_ins_q[11:8]];
  assign va       = vmap[a_ins_q[7:4]];
  assign vb       = vmap[a_ins_q[3:0]];
  assign sd       = smap[a_ins_q[11:7]];
  assign imm      = a_ins_q[7:0];
  assign saddr    = a_ins_q[6:0];
  assign saddr_ok = 32'(saddr) < SCALAR_MEM_DEPTH;
  assign a_vec    = vreg_q[vd];
  assign vm_eff   = vfwd_q ? vfwd_data_q : vm_rdata;
  assign sm_eff   = sfwd_q ? sfwd_data_q : sm_rdata;

  vpe_pkg::alu_ctrl_t alu_ctrl;
  logic [63:0] alu_a, alu_b, alu_res;
  logic        vw, sw, st, use_alu;
  logic [15:0] sval;
  logic [63:0] vval;
  vpe_pkg::status_e status;
  logic        vm_we, sm_we, vm_store;
  logic [15:0] vm_waddr16;
  logic [63:0] vm_wdata;

  // instruction and preload control
  always_comb begin
    alu_ctrl = '{op: vpe_pkg::ALU_XOR, use_imm: 1'b1, imm: imm};
    alu_a    = a_vec;
    alu_b    = vreg_q[vb];
    use_alu  = 1'b0;
    vw       = 1'b0;
    sw       = 1'b0;
    st       = 1'b0;
    vm_store = 1'b0;
    vm_we    = 1'b0;
    sm_we    = 1'b0;
    status   = vpe_pkg::ST_OK;
    case (a_func_q)
      vpe_pkg::FUNC_PRE_S: begin
        if (32'(a_paddr_q[6:0]) < SCALAR_MEM_DEPTH) sm_we = 1'b1;
        else status = vpe_pkg::ST_RANGE;
      end
      vpe_pkg::FUNC_PRE_V: begin
        if (32'(a_paddr_q) < VECTOR_MEM_DEPTH) vm_we = 1'b1;
        else status = vpe_pkg::ST_RANGE;
      end
      vpe_pkg::FUNC_EXEC: begin
        case (vpe_pkg::op_e'(a_ins_q[15:12]))
          vpe_pkg::OP_XOR: use_alu = 1'b1;
          vpe_pkg::OP_ADD: begin
            use_alu = 1'b1;
            alu_ctrl.op = vpe_pkg::ALU_ADD;
            alu_ctrl.use_imm = 1'b0;
            alu_a = vreg_q[va];
          end
          vpe_pkg::OP_SUB: begin
            use_alu = 1'b1;
            alu_ctrl.op = vpe_pkg::ALU_SUB;
            alu_ctrl.use_imm = 1'b0;
            alu_a = vreg_q[va];
          end
          vpe_pkg::OP_SHR: begin
            use_alu = 1'b1;
            alu_ctrl.op = vpe_pkg::ALU_SHR;
          end
          vpe_pkg::OP_SHL: begin
            use_alu = 1'b1;
            alu_ctrl.op = vpe_pkg::ALU_SHL;
          end
          vpe_pkg::OP_ADDI: begin
            use_alu = 1'b1;
            alu_ctrl.op = vpe_pkg::ALU_ADD;
          end
          vpe_pkg::OP_SUBI: begin
            use_alu = 1'b1;
            alu_ctrl.op = vpe_pkg::ALU_SUB;
          end
          vpe_pkg::OP_VLOAD: begin
            if (a_vaddr_ok_q) vw = 1'b1;
            else status = vpe_pkg::ST_RANGE;
          end
          vpe_pkg::OP_VSTORE: begin
            if (a_vaddr_ok_q) begin
              st = 1'b1;
              vm_store = 1'b1;
              vm_we = 1'b1;
            end else status = vpe_pkg::ST_RANGE;
          end
          vpe_pkg::OP_SLOAD: begin
            if (saddr_ok) sw = 1'b1;
            else status = vpe_pkg::ST_RANGE;
          end
          default: status = vpe_pkg::ST_UNIMPL;
        endcase
      end
      default: status = vpe_pkg::ST_UNIMPL;
    endcase
    if (use_alu) vw = 1'b1;
  end

  vpe_alu #(
    .VECTOR_LENGTH(VECTOR_LENGTH)
  ) u_alu (
    .ctrl_i(alu_ctrl),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  assign vval       = use_alu ? alu_res : (vm_eff & LaneMask);
  assign sval       = sm_eff;
  assign vm_waddr16 = vm_store ? a_vaddr_q : {8'd0, a_paddr_q};
  assign vm_wdata   = (vm_store ? a_vec : a_pdata_q) & LaneMask;

  // address of the incoming word, bypassing a scalar load ahead of it
  logic [SIW-1:0] n_sa;
  logic [15:0]    n_sval;
  assign n_sa   = smap[in_i.instruction[7:3]];
  assign n_sval = (adv && sw && sd == n_sa) ? sval : sreg_q[n_sa];

  // memories, writes retire as the word ahead leaves the issue register
  vpe_ram #(
    .WIDTH(64),
    .DEPTH(VECTOR_MEM_DEPTH)
  ) u_vmem (
    .clk_i  (clk_i),
    .we_i   (adv && vm_we),
    .waddr_i(VAW'(vm_waddr16)),
    .wdata_i(vm_wdata),
    .re_i   (in_acc),
    .raddr_i(VAW'(n_sval)),
    .rdata_o(vm_rdata)
  );

  vpe_ram #(
    .WIDTH(16),
    .DEPTH(SCALAR_MEM_DEPTH)
  ) u_smem (
    .clk_i  (clk_i),
    .we_i   (adv && sm_we),
    .waddr_i(SAW'(a_paddr_q[6:0])),
    .wdata_i(a_pdata_q[15:0]),
    .re_i   (in_acc),
    .raddr_i(SAW'(in_i.instruction[6:0])),
    .rdata_o(sm_rdata)
  );

  // issue register control and bypass capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (in_acc) begin
      a_vld_q <= 1'b1;
    end else if (adv) begin
      a_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_func_q     <= in_i.func;
      a_ins_q      <= in_i.instruction;
      a_paddr_q    <= in_i.preload_addr;
      a_pdata_q    <= in_i.preload_data;
      a_vaddr_q    <= n_sval;
      a_vaddr_ok_q <= 17'(n_sval) < 17'(VECTOR_MEM_DEPTH);
      vfwd_q       <= adv && vm_we && vm_waddr16 == n_sval;
      vfwd_data_q  <= vm_wdata;
      sfwd_q       <= adv && sm_we && a_paddr_q[6:0] == in_i.instruction[6:0];
      sfwd_data_q  <= a_pdata_q[15:0];
    end
  end

  // register banks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VECTOR_REGS; i++) vreg_q[i] <= '0;
      for (int i = 0; i < SCALAR_REGS; i++) sreg_q[i] <= '0;
    end else if (adv) begin
      if (vw) vreg_q[vd] <= vval;
      if (sw) sreg_q[sd] <= sval;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= adv || (out_vld_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_vw_q     <= vw;
      o_vd_q     <= vw ? 4'(vd) : 4'd0;
      o_vval_q   <= vw ? vval : 64'd0;
      o_sw_q     <= sw;
      o_sd_q     <= sw ? 5'(sd) : 5'd0;
      o_sval_q   <= sw ? sval : 16'd0;
      o_st_q     <= st;
      o_status_q <= status;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.vector_written = o_vw_q;
  assign out_o.vector_dest    = o_vd_q;
  assign out_o.vector_value   = o_vval_q;
  assign out_o.scalar_written = o_sw_q;
  assign out_o.scalar_dest    = o_sd_q;
  assign out_o.scalar_value   = o_sval_q;
  assign out_o.vector_stored  = o_st_q;
  assign out_o.status         = o_status_q;

endmodule

// ===== src/vpe_ram.sv =====
// ----------------------------------------------------------------------------
// vpe_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module vpe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/vpe_alu.sv =====
// ----------------------------------------------------------------------------
// vpe_alu
// lane-wise byte arithmetic: xor, add, sub and logical shifts
// ----------------------------------------------------------------------------
module vpe_alu #(
  parameter int VECTOR_LENGTH = vpe_pkg::VECTOR_LENGTH_DEF
) (
  input  vpe_pkg::alu_ctrl_t ctrl_i,
  input  logic [63:0]        a_i,
  input  logic [63:0]        b_i,
  output logic [63:0]        res_o
);

  // one independent byte per lane, inactive lanes read as zero
  always_comb begin
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] z;
    res_o = '0;
    for (int i = 0; i < vpe_pkg::MAX_LANES; i++) begin
      x = a_i[i*vpe_pkg::ELEM_BITS +: vpe_pkg::ELEM_BITS];
      y = ctrl_i.use_imm ? ctrl_i.imm : b_i[i*vpe_pkg::ELEM_BITS +: vpe_pkg::ELEM_BITS];
      case (ctrl_i.op)
        vpe_pkg::ALU_XOR: z = x ^ y;
        vpe_pkg::ALU_ADD: z = x + y;
        vpe_pkg::ALU_SUB: z = x - y;
        vpe_pkg::ALU_SHR: z = (ctrl_i.imm[7:3] != '0) ? 8'd0 : (x >> ctrl_i.imm[2:0]);
        vpe_pkg::ALU_SHL: z = (ctrl_i.imm[7:3] != '0) ? 8'd0 : (x << ctrl_i.imm[2:0]);
        default:          z = 8'd0;
      endcase
      if (i < VECTOR_LENGTH) res_o[i*vpe_pkg::ELEM_BITS +: vpe_pkg::ELEM_BITS] = z;
    end
  end

endmodule

// ===== src/vpe_checker.sv =====
// ----------------------------------------------------------------------------
// vpe_checker
// port level checks of the vector processor execute block
// ----------------------------------------------------------------------------
`include "vector_processor_execute_defines.svh"

module vpe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        vector_written_i,
  input logic [3:0]  vector_dest_i,
  input logic        scalar_written_i,
  input logic [4:0]  scalar_dest_i,
  input logic [15:0] scalar_value_i,
  input logic        vector_stored_i,
  input logic [1:0]  status_i
);

  logic [7:0] out_word;
  assign out_word = {vector_written_i, vector_dest_i, scalar_written_i, vector_stored_i,
                     status_i[0]};

  // the flags, vector dest and status bit 0 of a stalled result word hold
  `VPE_HOLD(a_out_hold, clk_i, rst_ni, out_valid_i, out_ready_i, out_word)

  // one instruction writes at most one kind of state
  `VPE_ASSERT(a_one_write, clk_i, rst_ni,
    out_valid_i |-> $onehot0({vector_written_i, scalar_written_i, vector_stored_i}))

  // an error status never comes with a write
  `VPE_ASSERT(a_err_quiet, clk_i, rst_ni,
    (out_valid_i && status_i != vpe_pkg::ST_OK) |->
      (!vector_written_i && !scalar_written_i && !vector_stored_i))

  // scalar fields are zero when no scalar register was written
  `VPE_ASSERT(a_scalar_zero, clk_i, rst_ni,
    (out_valid_i && !scalar_written_i) |-> (scalar_dest_i == '0 && scalar_value_i == '0))

endmodule

bind vector_processor_execute vpe_checker u_vpe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .vector_written_i(out_o.vector_written),
  .vector_dest_i   (out_o.vector_dest),
  .scalar_written_i(out_o.scalar_written),
  .scalar_dest_i   (out_o.scalar_dest),
  .scalar_value_i  (out_o.scalar_value),
  .vector_stored_i (out_o.vector_stored),
  .status_i        (out_o.status)
);
